[design/cpc_pkg.sv]
// ----------------------------------------------------------------------------
// Card punch controller package
// Shared transaction types, codes and constants for the card punch controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

  // Channel event kinds carried in the func field.
  localparam logic [2:0] FUNC_CODE   = 3'd0;
  localparam logic [2:0] FUNC_DATA   = 3'd1;
  localparam logic [2:0] FUNC_STATUS = 3'd2;
  localparam logic [2:0] FUNC_DISC   = 3'd3;
  localparam logic [2:0] FUNC_TICK   = 3'd4;

  // Fixed function codes.
  localparam logic [11:0] FC_DESELECT   = 12'o0000;
  localparam logic [11:0] FC_BINARY     = 12'o0001;
  localparam logic [11:0] FC_BCD        = 12'o0002;
  localparam logic [11:0] FC_OFFSET     = 12'o0003;
  localparam logic [11:0] FC_CHECK_LAST = 12'o0004;
  localparam logic [11:0] FC_CLEAR     = 12'o0005;
  localparam logic [11:0] FC_RDY_EN     = 12'o0020;
  localparam logic [11:0] FC_RDY_DIS    = 12'o0021;
  localparam logic [11:0] FC_EOI_EN     = 12'o0022;
  localparam logic [11:0] FC_EOI_DIS    = 12'o0023;
  localparam logic [11:0] FC_ERR_EN     = 12'o0024;
  localparam logic [11:0] FC_ERR_DIS    = 12'o0025;

  // Status bits.
  localparam logic [11:0] ST_READY     = 12'o0201;
  localparam logic [11:0] ST_READY_INT = 12'o0200;
  localparam logic [11:0] ST_EOI_INT   = 12'o0400;
  localparam logic [11:0] ST_ERR_INT   = 12'o1000;
  localparam logic [11:0] ST_NON_INT   = 12'o2177;

  // Raw binary card marker in the low five bits of the first word.
  localparam logic [4:0] RAW_MARK = 5'o05;

  // Selected operation.
  localparam logic [1:0] SEL_NONE   = 2'd0;
  localparam logic [1:0] SEL_OUTPUT = 2'd1;
  localparam logic [1:0] SEL_STATUS = 2'd2;

  // Emitted code kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HOL  = 2'd1;
  localparam logic [1:0] KIND_BCD  = 2'd2;
  localparam logic [1:0] KIND_RAW  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MOTION_DELAY = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_SEL   = 2'd1;
  localparam logic [1:0] CFG_STATUS_SEL   = 2'd2;
  localparam logic [1:0] CFG_MASTER_CLR   = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  RST_MOTION_DELAY = 8'd20;
  localparam logic [11:0] RST_OUTPUT_SEL   = 12'd1400;
  localparam logic [11:0] RST_STATUS_SEL   = 12'd1300;
  localparam logic [11:0] RST_MASTER_CLR   = 12'd1700;

  localparam logic [7:0] MOTION_SAT = 8'd255;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] word;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        card_done;
    logic [8:0]  card_length;
    logic        raw_card;
    logic [8:0]  column;
    logic [1:0]  code_kind;
    logic [11:0] code;
    logic [11:0] status_word;
    logic        interrupt;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  motion_delay_ticks;
    logic [11:0] output_select_code;
    logic [11:0] status_select_code;
    logic [11:0] master_clear_code;
  } cfg_t;

  // Status bits that the three enable flags unmask.
  function automatic logic [11:0] enable_bits(input logic [2:0] en);
    logic [11:0] m;
    m = '0;
    if (en[0]) m = m | ST_READY_INT;
    if (en[1]) m = m | ST_EOI_INT;
    if (en[2]) m = m | ST_ERR_INT;
    return m;
  endfunction

endpackage

`default_nettype wire

[design/cpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Card punch controller configuration registers
// Holds the motion delay and the three programmable function codes.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_cfg_regs
  import cpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [11:0] wr_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MOTION_DELAY: cfg_nxt.motion_delay_ticks = wr_data[7:0];
        CFG_OUTPUT_SEL:   cfg_nxt.output_select_code = wr_data;
        CFG_STATUS_SEL:   cfg_nxt.status_select_code = wr_data;
        CFG_MASTER_CLR:   cfg_nxt.master_clear_code  = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_delay_ticks <= RST_MOTION_DELAY;
      cfg_r.output_select_code <= RST_OUTPUT_SEL;
      cfg_r.status_select_code <= RST_STATUS_SEL;
      cfg_r.master_clear_code  <= RST_MASTER_CLR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[design/cpc_in_stage.sv]
// ----------------------------------------------------------------------------
// Card punch controller input stage
// Registers one incoming transaction ahead of the processing step.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_in_stage
  import cpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          s_valid,
  input  wire logic     s_ready,
  output in_item_t      s_data
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  assign in_ready  = !valid_r || s_ready;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !s_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s_valid = valid_r;
  assign s_data  = data_r;

endmodule

`default_nettype wire

[design/cpc_core.sv]
// ----------------------------------------------------------------------------
// Card punch controller core
// Holds the controller state and computes one result per processed event.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_core
  import cpc_pkg::*;
#(
  parameter int CARD_COLUMNS = 80
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  localparam logic [8:0] FULL_HOL = 9'(CARD_COLUMNS);
  localparam logic [8:0] FULL_RAW = 9'(CARD_COLUMNS * 4);

  logic        binary_r,  binary_nxt;
  logic        raw_r,     raw_nxt;
  logic [2:0]  int_en_r,  int_en_nxt;
  logic [11:0] status_r,  status_nxt;
  logic [8:0]  col_r,     col_nxt;
  logic [7:0]  motion_r,  motion_nxt;
  logic [1:0]  sel_r,     sel_nxt;

  logic        can_finish;
  logic        card_full;
  logic        raw_first;

  assign can_finish = (col_r != 9'd0);
  assign card_full  = raw_r ? (col_r >= FULL_RAW) : (col_r >= FULL_HOL);
  assign raw_first  = binary_r && (item.word[4:0] == RAW_MARK);

  always_comb begin
    binary_nxt = binary_r;
    raw_nxt    = raw_r;
    int_en_nxt = int_en_r;
    status_nxt = status_r;
    col_nxt    = col_r;
    motion_nxt = motion_r;
    sel_nxt    = sel_r;
    result     = '0;

    unique case (item.func)
      FUNC_CODE: begin
        if (item.word == cfg.output_select_code) begin
          status_nxt = ST_READY;
          sel_nxt    = SEL_OUTPUT;
        end else if (item.word == cfg.status_select_code) begin
          sel_nxt = SEL_STATUS;
        end else if (item.word != cfg.master_clear_code) begin
          case (item.word) inside
            FC_DESELECT, FC_CLEAR: begin
              int_en_nxt = 3'b000;
              binary_nxt = 1'b0;
            end
            FC_BINARY: binary_nxt = 1'b1;
            FC_BCD:    binary_nxt = 1'b0;
            FC_CHECK_LAST: begin
              if (can_finish) begin
                motion_nxt         = '0;
                col_nxt            = '0;
                result.card_done   = 1'b1;
                result.card_length = col_r;
              end
            end
            FC_RDY_EN: begin
              int_en_nxt[0] = 1'b1;
              status_nxt    = status_r & ~ST_READY_INT;
            end
            FC_RDY_DIS: begin
              int_en_nxt[0] = 1'b0;
              status_nxt    = status_r & ~ST_READY_INT;
            end
            FC_EOI_EN: begin
              int_en_nxt[1] = 1'b1;
              status_nxt    = status_r & ~ST_EOI_INT;
            end
            FC_EOI_DIS: begin
              int_en_nxt[1] = 1'b0;
              status_nxt    = status_r & ~ST_EOI_INT;
            end
            FC_ERR_EN: begin
              int_en_nxt[2] = 1'b1;
              status_nxt    = status_r & ~ST_ERR_INT;
            end
            FC_ERR_DIS: begin
              int_en_nxt[2] = 1'b0;
              status_nxt    = status_r & ~ST_ERR_INT;
            end
            default: ;  // offset and unknown codes do nothing
          endcase
        end
      end
      FUNC_DATA: begin
        if (sel_r == SEL_OUTPUT && motion_r >= cfg.motion_delay_ticks) begin
          if (card_full) begin
            // A full card is punched by the next offered word, which is refused.
            motion_nxt         = '0;
            col_nxt            = '0;
            result.card_done   = 1'b1;
            result.card_length = col_r;
          end else begin
            if (col_r == 9'd0) begin
              raw_nxt = raw_first;
            end
            result.accepted = 1'b1;
            result.column   = col_r;
            result.code     = item.word;
            if (raw_nxt) begin
              result.code_kind = KIND_RAW;
              col_nxt          = col_r + 9'd4;
            end else if (binary_r) begin
              result.code_kind = KIND_HOL;
              col_nxt          = col_r + 9'd1;
            end else begin
              result.code_kind = KIND_BCD;
              col_nxt          = col_r + 9'd2;
            end
          end
        end
      end
      FUNC_STATUS: begin
        if (sel_r == SEL_STATUS) begin
          result.status_word = status_r & (enable_bits(int_en_r) | ST_NON_INT);
        end
      end
      FUNC_DISC: begin
        status_nxt = status_r | ST_EOI_INT;
        if (can_finish) begin
          motion_nxt         = '0;
          col_nxt            = '0;
          result.card_done   = 1'b1;
          result.card_length = col_r;
        end
      end
      FUNC_TICK: begin
        if (motion_r != MOTION_SAT) begin
          motion_nxt = motion_r + 8'd1;
        end
      end
      default: ;
    endcase

    result.raw_card  = raw_nxt;
    result.interrupt = |(status_nxt & enable_bits(int_en_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_r <= 1'b0;
      raw_r    <= 1'b0;
      int_en_r <= 3'b000;
      status_r <= ST_READY;
      col_r    <= '0;
      motion_r <= MOTION_SAT;
      sel_r    <= SEL_NONE;
    end else if (step) begin
      binary_r <= binary_nxt;
      raw_r    <= raw_nxt;
      int_en_r <= int_en_nxt;
      status_r <= status_nxt;
      col_r    <= col_nxt;
      motion_r <= motion_nxt;
      sel_r    <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

[design/cpc_out_stage.sv]
// ----------------------------------------------------------------------------
// Card punch controller output stage
// Result register that holds one transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_out_stage
  import cpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      r_valid,
  output logic           r_ready,
  input  wire out_item_t r_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign r_ready   = !valid_r || out_ready;
  assign valid_nxt = (r_valid && r_ready) || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (r_valid && r_ready) begin
      data_r <= r_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[design/card_punch_controller_top.sv]
// ----------------------------------------------------------------------------
// Card punch controller top level
// Channel controller for a card punch: function codes, data words, status
// reads, disconnects and time ticks in; one result transaction out per event.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Direction  Payload
//   input     in_valid / in_ready / in_data       in         in_item_t (func, word)
//   result    out_valid / out_ready / out_data    out        out_item_t
//   config    cfg_valid / cfg_ready / cfg_index,  in         2-bit index, 12-bit data
//             cfg_data
//
// Every input transaction yields exactly one result transaction. An event is
// registered at the input, processed against the controller state, and lands
// in the result register, so the block sustains one transaction per cycle
// while out_ready is high. The only stall comes from out_ready: a held result
// backs up the input register, and in_ready drops once both are full. Reset
// is synchronous and active low; it restores the register defaults and the
// power-up controller state. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module card_punch_controller_top
  import cpc_pkg::*;
#(
  parameter int CARD_COLUMNS = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t      cfg;
  logic      s_valid;
  logic      s_ready;
  in_item_t  s_data;
  out_item_t result;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  cpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cpc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data)
  );

  // The controller state advances exactly when a processed event moves into
  // the result register, so a stalled result never updates state twice.
  cpc_core #(
    .CARD_COLUMNS (CARD_COLUMNS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s_valid && s_ready),
    .item   (s_data),
    .cfg    (cfg),
    .result (result)
  );

  cpc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_valid   (s_valid),
    .r_ready   (s_ready),
    .r_data    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[design/cpc_checker.sv]
// ----------------------------------------------------------------------------
// Card punch controller checker
// Port-level assertions on the result channel of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_port_checks
  import cpc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted word always carries a code kind.
  a_accept_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.code_kind != KIND_NONE)
    else $error("accepted word without code kind");

  // Without an accepted word no code, column or kind is shown.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.code_kind == KIND_NONE && out_data.column == 9'd0 &&
      out_data.code == 12'd0)
    else $error("code fields set on a refused event");

  // A completed card has a length, and only a completed card has one.
  a_card_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.card_done == (out_data.card_length != 9'd0)))
    else $error("card length inconsistent with card completion");

  // A word is never accepted in the same event that completes a card.
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.card_done |-> !out_data.accepted)
    else $error("word accepted while completing a card");

endmodule

bind card_punch_controller_top cpc_port_checks u_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[dv/cpc_checker.sv]
// ----------------------------------------------------------------------------
// Card punch controller checker
// Watches the input, result and register write channels of the controller,
// predicts one reply per input transaction and compares every reply field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module cpc_checker
  import cpc_pkg::*;
#(
  parameter int CARD_COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          n_mismatches,
  output int          n_pending,
  output int          n_results,
  output int          n_words,
  output int          n_cards,
  output int          n_raw_cards
);

  // A broken design would flood the log, so only the first reports are shown.
  localparam int MAX_REPORTS = 100;

  cfg_t        regs;
  logic        hol_mode;
  logic        raw_active;
  logic [2:0]  irq_mask;
  logic [11:0] dev_status;
  logic [8:0]  cols_used;
  logic [7:0]  motion_age;
  logic [1:0]  sel_mode;

  out_item_t   replies_due[$];
  out_item_t   next_reply;
  out_item_t   oldest;

  function automatic logic [11:0] irq_bits(input logic [2:0] m);
    return ({12{m[0]}} & ST_READY_INT) | ({12{m[1]}} & ST_EOI_INT) |
           ({12{m[2]}} & ST_ERR_INT);
  endfunction

  // Punches the card in progress, if it holds anything, and starts the motion delay.
  task automatic close_card(inout out_item_t r);
    if (cols_used != 0) begin
      r.card_done   = 1'b1;
      r.card_length = cols_used;
      motion_age    = '0;
      cols_used     = '0;
    end
  endtask

  task automatic process_channel_event(input in_item_t ev, output out_item_t r);
    logic [11:0] w;
    int          cap;
    w = ev.word;
    r = '0;
    case (ev.func)
      FUNC_CODE: begin
        // Register-defined codes take priority over the fixed ones.
        if (w == regs.output_select_code) begin
          dev_status = ST_READY;
          sel_mode   = SEL_OUTPUT;
        end else if (w == regs.status_select_code) begin
          sel_mode = SEL_STATUS;
        end else if (w != regs.master_clear_code) begin
          case (w) inside
            FC_DESELECT, FC_CLEAR: begin
              irq_mask = '0;
              hol_mode = 1'b0;
            end
            FC_BINARY:     hol_mode = 1'b1;
            FC_BCD:        hol_mode = 1'b0;
            FC_CHECK_LAST: close_card(r);
            FC_RDY_EN:  begin irq_mask[0] = 1'b1; dev_status &= ~ST_READY_INT; end
            FC_RDY_DIS: begin irq_mask[0] = 1'b0; dev_status &= ~ST_READY_INT; end
            FC_EOI_EN:  begin irq_mask[1] = 1'b1; dev_status &= ~ST_EOI_INT; end
            FC_EOI_DIS: begin irq_mask[1] = 1'b0; dev_status &= ~ST_EOI_INT; end
            FC_ERR_EN:  begin irq_mask[2] = 1'b1; dev_status &= ~ST_ERR_INT; end
            FC_ERR_DIS: begin irq_mask[2] = 1'b0; dev_status &= ~ST_ERR_INT; end
            default: ;
          endcase
        end
      end
      FUNC_DATA: begin
        if (sel_mode == SEL_OUTPUT && motion_age >= regs.motion_delay_ticks) begin
          cap = raw_active ? CARD_COLUMNS * 4 : CARD_COLUMNS;
          if (int'(cols_used) >= cap) begin
            // A full card is punched by the next word, which is refused.
            close_card(r);
          end else begin
            if (cols_used == 0) raw_active = hol_mode && (w[4:0] == RAW_MARK);
            r.accepted = 1'b1;
            r.column   = cols_used;
            r.code     = w;
            if (raw_active) begin
              r.code_kind = KIND_RAW;
              cols_used   = cols_used + 9'd4;
            end else if (hol_mode) begin
              r.code_kind = KIND_HOL;
              cols_used   = cols_used + 9'd1;
            end else begin
              r.code_kind = KIND_BCD;
              cols_used   = cols_used + 9'd2;
            end
          end
        end
      end
      FUNC_STATUS: begin
        if (sel_mode == SEL_STATUS) r.status_word = dev_status & (irq_bits(irq_mask) | ST_NON_INT);
      end
      FUNC_DISC: begin
        dev_status |= ST_EOI_INT;
        close_card(r);
      end
      FUNC_TICK: begin
        if (motion_age != MOTION_SAT) motion_age = motion_age + 8'd1;
      end
      default: ;
    endcase
    r.raw_card  = raw_active;
    r.interrupt = |(dev_status & irq_bits(irq_mask));
  endtask

  task automatic check_field(input string fname, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      n_mismatches++;
      if (n_mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs         = {RST_MOTION_DELAY, RST_OUTPUT_SEL, RST_STATUS_SEL, RST_MASTER_CLR};
      hol_mode     = 1'b0;
      raw_active   = 1'b0;
      irq_mask     = '0;
      dev_status   = ST_READY;
      cols_used    = '0;
      motion_age   = MOTION_SAT;
      sel_mode     = SEL_NONE;
      replies_due.delete();
      n_mismatches = 0;
      n_results    = 0;
      n_words      = 0;
      n_cards      = 0;
      n_raw_cards  = 0;
    end else begin
      // Register writes are to happen only while the controller is idle; the checker does not enforce it.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MOTION_DELAY: regs.motion_delay_ticks = cfg_data[7:0];
          CFG_OUTPUT_SEL:   regs.output_select_code = cfg_data;
          CFG_STATUS_SEL:   regs.status_select_code = cfg_data;
          CFG_MASTER_CLR:   regs.master_clear_code  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        process_channel_event(in_data, next_reply);
        replies_due.push_back(next_reply);
        if (next_reply.accepted) n_words++;
        if (next_reply.card_done) begin
          n_cards++;
          if (next_reply.raw_card) n_raw_cards++;
        end
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (replies_due.size() == 0) begin
          n_mismatches++;
          $display("%0t: result transaction arrived with no prediction pending", $time);
        end else begin
          oldest = replies_due.pop_front();
          check_field("accepted",    12'(oldest.accepted),    12'(out_data.accepted));
          check_field("card_done",   12'(oldest.card_done),   12'(out_data.card_done));
          check_field("card_length", 12'(oldest.card_length), 12'(out_data.card_length));
          check_field("raw_card",    12'(oldest.raw_card),    12'(out_data.raw_card));
          check_field("column",      12'(oldest.column),      12'(out_data.column));
          check_field("code_kind",   12'(oldest.code_kind),   12'(out_data.code_kind));
          check_field("code",        oldest.code,             out_data.code);
          check_field("status_word", oldest.status_word,      out_data.status_word);
          check_field("interrupt",   12'(oldest.interrupt),   12'(out_data.interrupt));
        end
      end
    end
    n_pending <= replies_due.size();
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Card punch controller testbench
// Drives channel events and register writes into the controller, applies
// random backpressure on the result channel and leaves all checking to the
// checker instance, whose mismatch count decides the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import cpc_pkg::*;

  localparam int CARD_COLUMNS = 80;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  int n_mismatches;
  int n_pending;
  int n_results;
  int n_words;
  int n_cards;
  int n_raw_cards;

  // Register values as last written, so that sessions can use the live codes.
  cfg_t live_regs;

  // Percent chance of an idle burst before each input transaction and of a
  // stall burst at each ready check on the result side. Both are reshuffled per session.
  int gap_pct   = 0;
  int stall_pct = 0;
  int items_sent = 0;

  always #10 clk = ~clk;

  card_punch_controller_top #(
    .CARD_COLUMNS(CARD_COLUMNS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cpc_checker #(
    .CARD_COLUMNS(CARD_COLUMNS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .n_mismatches(n_mismatches),
    .n_pending   (n_pending),
    .n_results   (n_results),
    .n_words     (n_words),
    .n_cards     (n_cards),
    .n_raw_cards (n_raw_cards)
  );

  // The result side stalls in random bursts. Between bursts ready is high,
  // and with stall_pct at zero it never drops.
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [11:0] rand_word();
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [11:0] pick_enable();
    case ($urandom_range(0, 5))
      0:       return FC_RDY_EN;
      1:       return FC_RDY_DIS;
      2:       return FC_EOI_EN;
      3:       return FC_EOI_DIS;
      4:       return FC_ERR_EN;
      default: return FC_ERR_DIS;
    endcase
  endfunction

  // Any function code the controller knows, plus the occasional random one.
  function automatic logic [11:0] pick_code();
    case ($urandom_range(0, 11))
      0:       return FC_DESELECT;
      1:       return FC_BINARY;
      2:       return FC_BCD;
      3:       return FC_OFFSET;
      4:       return FC_CHECK_LAST;
      5:       return FC_CLEAR;
      6:       return live_regs.output_select_code;
      7:       return live_regs.status_select_code;
      8:       return live_regs.master_clear_code;
      9:       return rand_word();
      default: return pick_enable();
    endcase
  endfunction

  // Offers one transaction and returns at the edge where it is taken. Valid is
  // only dropped for an idle burst, never between back-to-back transactions.
  task automatic send_event(input logic [2:0] f, input logic [11:0] w);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {f, w};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Funcs 5 to 7 do nothing and are not counted as stimulus.
    if (f <= FUNC_TICK) items_sent++;
  endtask

  // Holds the input off until every predicted reply has come back. The first
  // edge lets the checker account for a transaction taken at the last edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Rewrites all four registers while the controller is idle.
  task automatic load_regs(input logic [7:0] dly, input logic [11:0] osel,
                           input logic [11:0] ssel, input logic [11:0] mclr);
    settle();
    write_reg(CFG_MOTION_DELAY, {4'd0, dly});
    write_reg(CFG_OUTPUT_SEL, osel);
    write_reg(CFG_STATUS_SEL, ssel);
    write_reg(CFG_MASTER_CLR, mclr);
    cfg_valid <= 1'b0;
    live_regs.motion_delay_ticks = dly;
    live_regs.output_select_code = osel;
    live_regs.status_select_code = ssel;
    live_regs.master_clear_code  = mclr;
  endtask

  // One well-formed punch job: select output, pick a mode, let the card
  // motion settle, send up to a card's worth of words, usually close it, then
  // read status back. A third of the jobs run one word past a full card so
  // that the extra word punches the card. Now and then too few ticks go out,
  // so early words get refused during the motion delay.
  task automatic punch_session();
    int          style;
    int          n_ticks;
    int          n_data;
    int          cap;
    int          k;
    logic [11:0] w;
    style = $urandom_range(0, 2);   // 0 BCD, 1 Hollerith, 2 raw binary
    send_event(FUNC_CODE, live_regs.output_select_code);
    send_event(FUNC_CODE, (style == 0) ? FC_BCD : FC_BINARY);
    repeat ($urandom_range(0, 2)) send_event(FUNC_CODE, pick_enable());
    if ($urandom_range(0, 7) == 0)
      n_ticks = $urandom_range(0, live_regs.motion_delay_ticks);
    else
      n_ticks = live_regs.motion_delay_ticks + $urandom_range(0, 2);
    repeat (n_ticks) send_event(FUNC_TICK, rand_word());
    // BCD words fill two columns each; Hollerith one; raw words four of 320.
    cap = (style == 0) ? CARD_COLUMNS / 2 : CARD_COLUMNS;
    n_data = ($urandom_range(0, 2) == 0) ? cap + 1 : $urandom_range(1, cap);
    for (k = 0; k < n_data; k++) begin
      w = rand_word();
      if (k == 0 && style == 2) w[4:0] = RAW_MARK;
      else if (k == 0 && w[4:0] == RAW_MARK) w[0] = ~w[0];
      send_event(FUNC_DATA, w);
      if ($urandom_range(0, 24) == 0)
        send_event(($urandom_range(0, 1) != 0) ? FUNC_TICK : FUNC_STATUS, rand_word());
    end
    // Partial cards are usually closed by a disconnect or a check-last code;
    // the rest carry over into the next job.
    if (n_data <= cap) begin
      case ($urandom_range(0, 7))
        0:          ;
        1, 2, 3:    send_event(FUNC_DISC, rand_word());
        default:    send_event(FUNC_CODE, FC_CHECK_LAST);
      endcase
    end
    send_event(FUNC_CODE, live_regs.status_select_code);
    send_event(FUNC_STATUS, rand_word());
    if ($urandom_range(0, 3) == 0) send_event(FUNC_DATA, rand_word());
  endtask

  // Unstructured traffic: any func, any word, or any known function code.
  task automatic noise_burst();
    logic [2:0] f;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) != 0) begin
        send_event(FUNC_CODE, pick_code());
      end else begin
        f = 3'($urandom_range(0, 7));
        send_event(f, rand_word());
      end
    end
  endtask

  // Mostly punch jobs with some noise between them. Quiet phases keep both
  // sides at full rate and skip the drain pauses.
  task automatic run_phase(input int budget, input logic quiet);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if (!quiet) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      if ($urandom_range(0, 4) == 0) noise_burst();
      else punch_session();
      if (!quiet && $urandom_range(0, 9) == 0) settle();
    end
  endtask

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    live_regs.motion_delay_ticks = RST_MOTION_DELAY;
    live_regs.output_select_code = RST_OUTPUT_SEL;
    live_regs.status_select_code = RST_STATUS_SEL;
    live_regs.master_clear_code  = RST_MASTER_CLR;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks against the power-up register values, with light
    // result stalls and no input gaps.
    stall_pct = 10;
    send_event(FUNC_TICK, 12'd0);                       // motion count already saturated
    send_event(FUNC_DATA, 12'hFFF);                     // nothing selected, refused
    send_event(FUNC_STATUS, 12'hFFF);                   // status not selected, reads zero
    send_event(FUNC_CODE, live_regs.status_select_code);
    send_event(FUNC_DATA, 12'd0);                       // status selected, refused
    send_event(FUNC_CODE, FC_RDY_EN);
    send_event(FUNC_CODE, FC_EOI_EN);
    send_event(FUNC_CODE, FC_ERR_EN);
    send_event(FUNC_DISC, 12'd0);                       // empty card, raises end of operation
    send_event(FUNC_STATUS, 12'd0);
    send_event(FUNC_CODE, live_regs.master_clear_code); // accepted but does nothing
    send_event(FUNC_CODE, FC_OFFSET);
    send_event(FUNC_CODE, 12'hFFF);                     // unknown code
    send_event(FUNC_CODE, live_regs.output_select_code);
    send_event(FUNC_CODE, FC_BINARY);
    send_event(FUNC_DATA, {7'd0, RAW_MARK});            // first word marks a raw card
    send_event(FUNC_DATA, 12'hFFF);
    send_event(FUNC_CODE, FC_CHECK_LAST);               // punches the two-word raw card
    send_event(FUNC_DATA, 12'd0);                       // refused during card motion
    send_event(3'd5, 12'hFFF);
    send_event(3'd6, 12'd0);
    send_event(3'd7, 12'hFFF);
    send_event(FUNC_CODE, FC_CLEAR);
    send_event(FUNC_CODE, FC_RDY_DIS);
    send_event(FUNC_CODE, FC_EOI_DIS);
    send_event(FUNC_CODE, FC_ERR_DIS);
    send_event(FUNC_CODE, FC_DESELECT);

    // Zero motion delay; output select sits on the deselect code and the
    // master clear code hides the ready-enable code.
    load_regs(8'd0, 12'd0, 12'd4095, FC_RDY_EN);
    run_phase(220, 1'b0);
    // Back to the power-up values.
    load_regs(RST_MOTION_DELAY, RST_OUTPUT_SEL, RST_STATUS_SEL, RST_MASTER_CLR);
    run_phase(210, 1'b0);
    // Short delay, random codes.
    load_regs(8'($urandom_range(1, 8)), rand_word(), rand_word(), rand_word());
    run_phase(170, 1'b0);
    // Longest delay; status select shadows deselect and master clear shadows clear.
    load_regs(8'd255, 12'd4095, FC_DESELECT, FC_CLEAR);
    run_phase(100, 1'b0);
    // Closing stretch at full rate on both sides.
    load_regs(8'd1, RST_OUTPUT_SEL, RST_STATUS_SEL, RST_MASTER_CLR);
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(120, 1'b1);

    settle();
    $display("Checked %0d result transactions: %0d data words taken, %0d cards punched (%0d raw).",
             n_results, n_words, n_cards, n_raw_cards);
    $display("Register settings covered motion delays from 0 to 255 and select codes at both ends.");
    if (n_mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
